// ===== rtl/fmt_pkg.sv =====
// Shared types and constants of the failure memory table.
`default_nettype none
package fmt_pkg;

  localparam int MODE_W   = 3;
  localparam int KEY_W    = 64;
  localparam int LEVEL_W  = 32;
  localparam int MARGIN_W = 21;
  localparam int COUNT_W  = 8;

  localparam logic [LEVEL_W-1:0]  RETRY_SENTINEL = 32'd1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX      = 8'd255;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET   = 21'd8192;

  typedef enum logic [MODE_W-1:0] {
    MODE_QUERY         = 3'd0,
    MODE_RECORD        = 3'd1,
    MODE_RETRY_NEXT    = 3'd2,
    MODE_CLEAR_RETRY   = 3'd3,
    MODE_CLEAR_SESSION = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_FSCAN,
    ST_RDLAST,
    ST_MOVE,
    ST_OSCAN,
    ST_RECCHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [LEVEL_W-1:0] level;
  } fail_entry_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } open_entry_t;

endpackage
`default_nettype wire

// ===== rtl/fmt_if.sv =====
// Request, response and configuration channel interfaces.
`default_nettype none
interface fmt_req_if;
  logic                          valid;
  logic                          ready;
  logic [fmt_pkg::MODE_W-1:0]    mode;
  logic [fmt_pkg::KEY_W-1:0]     key;
  logic [fmt_pkg::LEVEL_W-1:0]   current_level;
  logic [fmt_pkg::LEVEL_W-1:0]   record_level;
  modport source (output valid, mode, key, current_level, record_level, input ready);
  modport sink (input valid, mode, key, current_level, record_level, output ready);
endinterface

interface fmt_resp_if;
  logic                          valid;
  logic                          ready;
  logic                          blocked;
  logic [fmt_pkg::COUNT_W-1:0]   open_fail_count;
  modport source (output valid, blocked, open_fail_count, input ready);
  modport sink (input valid, blocked, open_fail_count, output ready);
endinterface

interface fmt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fmt_pkg::MARGIN_W-1:0]  retry_margin;
  modport source (output valid, retry_margin, input ready);
  modport sink (input valid, retry_margin, output ready);
endinterface
`default_nettype wire

// ===== rtl/failure_memory_table.sv =====
// Failure memory table: top level with sequencer and both key tables.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | mode, key, current_level, record_level
//  resp    | out | valid / ready | blocked, open_fail_count
//  cfg     | in  | valid / ready | retry_margin (always ready)
//
// Query and record scan the failure table entry by entry and stop at a match; a query that is
// not blocked removes its entry by swap-remove with the last one. Retry-next scans the open
// table, then the failure table. Clear retryable removes every retry entry; clear session
// empties both tables. A new transaction is taken only once the last one is done.
// Reset empties both tables through their counts at once; no clearing pass.
// A transaction waits in the output register; the next one runs meanwhile.
`default_nettype none
module failure_memory_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  fmt_req_if.sink     req,
  fmt_resp_if.source  resp,
  fmt_cfg_if.sink     cfg
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);
  localparam int LW = fmt_pkg::LEVEL_W;
  localparam int CW = fmt_pkg::COUNT_W;

  fmt_pkg::state_t state, state_next;

  logic [fmt_pkg::MODE_W-1:0]   mode_r;
  logic [fmt_pkg::KEY_W-1:0]    key_r;
  logic [LW-1:0]                cur_r;
  logic [LW-1:0]                rec_r;
  logic [fmt_pkg::MARGIN_W-1:0] margin;

  logic [CNT_W-1:0] fail_count, fail_count_next;
  logic [CNT_W-1:0] open_entries, open_entries_next;
  logic [fmt_pkg::KEY_W-1:0] fallback_key, fallback_key_next;
  logic fallback_valid, fallback_valid_next;
  logic [CNT_W-1:0] ptr, ptr_next;
  logic [IDX_W-1:0] dptr, dptr_next;
  logic dvalid, dvalid_next;
  logic res_blocked, res_blocked_next;
  logic [CW-1:0] res_count, res_count_next;

  logic out_valid;
  logic out_blocked;
  logic [CW-1:0] out_count;
  logic out_load;

  fmt_pkg::fail_entry_t fmem [TABLE_ENTRIES];
  fmt_pkg::open_entry_t omem [TABLE_ENTRIES];
  fmt_pkg::fail_entry_t f_rdata, f_wdata;
  fmt_pkg::open_entry_t o_rdata, o_wdata;
  logic f_rd_en, f_we, o_rd_en, o_we;
  logic [IDX_W-1:0] f_raddr, f_waddr, o_raddr, o_waddr;

  logic accept;
  logic fb_hit;
  logic f_in_range, f_hit, f_end;
  logic o_in_range, o_hit, o_end;
  logic [LW:0] q_sum;
  logic q_block;
  logic [CW-1:0] o_bumped;
  logic [CNT_W-1:0] last_idx;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == fmt_pkg::ST_IDLE);
  assign cfg.ready = 1'b1;
  assign resp.valid           = out_valid;
  assign resp.blocked         = out_blocked;
  assign resp.open_fail_count = out_count;

  assign fb_hit     = fallback_valid && (fallback_key == key_r);
  assign f_in_range = ptr < fail_count;
  assign o_in_range = ptr < open_entries;
  assign f_hit = dvalid && ((mode_r == fmt_pkg::MODE_CLEAR_RETRY) ?
                            (f_rdata.level == fmt_pkg::RETRY_SENTINEL) :
                            (f_rdata.key == key_r));
  assign f_end = !dvalid && !f_in_range;
  assign o_hit = dvalid && (o_rdata.key == key_r);
  assign o_end = !dvalid && !o_in_range;

  // level + margin taken one bit wider, so no wrap
  assign q_sum   = {1'b0, f_rdata.level} + (LW + 1)'(margin);
  assign q_block = (f_rdata.level == '0) || (f_rdata.level == fmt_pkg::RETRY_SENTINEL) ||
                   ({1'b0, cur_r} < q_sum);
  assign o_bumped = (o_rdata.count == fmt_pkg::COUNT_MAX) ? fmt_pkg::COUNT_MAX :
                    o_rdata.count + CW'(1);
  assign last_idx = fail_count - CNT_W'(1);

  always_comb begin
    state_next = state;
    case (state)
      fmt_pkg::ST_IDLE: begin
        if (accept) state_next = fmt_pkg::ST_START;
      end
      fmt_pkg::ST_START: begin
        case (mode_r)
          fmt_pkg::MODE_QUERY:       state_next = fb_hit ? fmt_pkg::ST_DONE : fmt_pkg::ST_FSCAN;
          fmt_pkg::MODE_RECORD:      state_next = (fail_count >= FULL) ? fmt_pkg::ST_DONE :
                                                  fmt_pkg::ST_FSCAN;
          fmt_pkg::MODE_RETRY_NEXT:  state_next = fmt_pkg::ST_OSCAN;
          fmt_pkg::MODE_CLEAR_RETRY: state_next = fmt_pkg::ST_FSCAN;
          default:                   state_next = fmt_pkg::ST_DONE;
        endcase
      end
      fmt_pkg::ST_FSCAN: begin
        if (f_hit) begin
          if (mode_r == fmt_pkg::MODE_CLEAR_RETRY) state_next = fmt_pkg::ST_RDLAST;
          else if (mode_r == fmt_pkg::MODE_QUERY && !q_block) state_next = fmt_pkg::ST_RDLAST;
          else state_next = fmt_pkg::ST_DONE;
        end else if (f_end) begin
          state_next = fmt_pkg::ST_DONE;
        end
      end
      fmt_pkg::ST_RDLAST: state_next = fmt_pkg::ST_MOVE;
      fmt_pkg::ST_MOVE: begin
        state_next = (mode_r == fmt_pkg::MODE_CLEAR_RETRY) ? fmt_pkg::ST_FSCAN : fmt_pkg::ST_DONE;
      end
      fmt_pkg::ST_OSCAN: begin
        if (o_hit || o_end) state_next = fmt_pkg::ST_RECCHK;
      end
      fmt_pkg::ST_RECCHK: begin
        state_next = (fail_count >= FULL) ? fmt_pkg::ST_DONE : fmt_pkg::ST_FSCAN;
      end
      fmt_pkg::ST_DONE: begin
        if (!out_valid || resp.ready) state_next = fmt_pkg::ST_IDLE;
      end
      default: state_next = fmt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    fail_count_next     = fail_count;
    open_entries_next   = open_entries;
    fallback_key_next   = fallback_key;
    fallback_valid_next = fallback_valid;
    ptr_next            = ptr;
    dptr_next           = dptr;
    dvalid_next         = dvalid;
    res_blocked_next    = res_blocked;
    res_count_next      = res_count;
    out_load            = 1'b0;
    f_rd_en = 1'b0;
    f_raddr = ptr[IDX_W-1:0];
    f_we    = 1'b0;
    f_waddr = dptr;
    f_wdata = f_rdata;
    o_rd_en = 1'b0;
    o_raddr = ptr[IDX_W-1:0];
    o_we    = 1'b0;
    o_waddr = dptr;
    o_wdata = '{key: key_r, count: o_bumped};
    case (state)
      fmt_pkg::ST_START: begin
        res_blocked_next = 1'b0;
        res_count_next   = '0;
        ptr_next         = '0;
        dvalid_next      = 1'b0;
        case (mode_r)
          fmt_pkg::MODE_QUERY: begin
            if (fb_hit) res_blocked_next = 1'b1;
          end
          fmt_pkg::MODE_RETRY_NEXT: begin
            fallback_key_next   = key_r;
            fallback_valid_next = 1'b1;
          end
          fmt_pkg::MODE_CLEAR_RETRY: fallback_valid_next = 1'b0;
          fmt_pkg::MODE_CLEAR_SESSION: begin
            fail_count_next     = '0;
            open_entries_next   = '0;
            fallback_valid_next = 1'b0;
          end
          default: ;
        endcase
      end
      fmt_pkg::ST_FSCAN: begin
        if (f_hit) begin
          dvalid_next = 1'b0;
          if (mode_r == fmt_pkg::MODE_QUERY) res_blocked_next = q_block;
        end else begin
          f_rd_en     = f_in_range;
          dvalid_next = f_in_range;
          dptr_next   = ptr[IDX_W-1:0];
          if (f_in_range) ptr_next = ptr + CNT_W'(1);
          if (f_end && (mode_r == fmt_pkg::MODE_RECORD || mode_r == fmt_pkg::MODE_RETRY_NEXT))
          begin
            f_we    = 1'b1;
            f_waddr = fail_count[IDX_W-1:0];
            f_wdata = '{key: key_r,
                        level: (mode_r == fmt_pkg::MODE_RETRY_NEXT) ?
                               fmt_pkg::RETRY_SENTINEL : rec_r};
            fail_count_next = fail_count + CNT_W'(1);
          end
        end
      end
      fmt_pkg::ST_RDLAST: begin
        f_rd_en = 1'b1;
        f_raddr = last_idx[IDX_W-1:0];
      end
      fmt_pkg::ST_MOVE: begin
        f_we            = 1'b1;
        fail_count_next = last_idx;
        ptr_next        = CNT_W'(dptr);
        dvalid_next     = 1'b0;
      end
      fmt_pkg::ST_OSCAN: begin
        if (o_hit) begin
          o_we           = 1'b1;
          res_count_next = o_bumped;
        end else begin
          o_rd_en     = o_in_range;
          dvalid_next = o_in_range;
          dptr_next   = ptr[IDX_W-1:0];
          if (o_in_range) ptr_next = ptr + CNT_W'(1);
          if (o_end && open_entries < FULL) begin
            o_we              = 1'b1;
            o_waddr           = open_entries[IDX_W-1:0];
            o_wdata           = '{key: key_r, count: CW'(1)};
            open_entries_next = open_entries + CNT_W'(1);
            res_count_next    = CW'(1);
          end
        end
      end
      fmt_pkg::ST_RECCHK: begin
        ptr_next    = '0;
        dvalid_next = 1'b0;
      end
      fmt_pkg::ST_DONE: begin
        out_load = !out_valid || resp.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= fmt_pkg::ST_IDLE;
      margin         <= fmt_pkg::MARGIN_RESET;
      fail_count     <= '0;
      open_entries   <= '0;
      fallback_key   <= '0;
      fallback_valid <= 1'b0;
      ptr            <= '0;
      dvalid         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      fail_count     <= fail_count_next;
      open_entries   <= open_entries_next;
      fallback_key   <= fallback_key_next;
      fallback_valid <= fallback_valid_next;
      ptr            <= ptr_next;
      dvalid         <= dvalid_next;
      if (cfg.valid) margin <= cfg.retry_margin;
      if (out_load) out_valid <= 1'b1;
      else if (resp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    dptr        <= dptr_next;
    res_blocked <= res_blocked_next;
    res_count   <= res_count_next;
    if (accept) begin
      mode_r <= req.mode;
      key_r  <= req.key;
      cur_r  <= req.current_level;
      rec_r  <= req.record_level;
    end
    if (out_load) begin
      out_blocked <= res_blocked;
      out_count   <= res_count;
    end
  end

  always_ff @(posedge clk) begin
    if (f_we) fmem[f_waddr] <= f_wdata;
    if (f_rd_en) f_rdata <= fmem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (o_we) omem[o_waddr] <= o_wdata;
    if (o_rd_en) o_rdata <= omem[o_raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/fmt_checker.sv =====
// Port-level checks on the failure memory table, bound to the top level.
`default_nettype none
module fmt_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        out_blocked,
  input wire logic [fmt_pkg::COUNT_W-1:0] out_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_blocked) && $stable(out_count))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new transaction taken while one is in progress");

  a_fields_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_blocked && out_count != '0))
    else $error("blocked and open failure count both set");

endmodule

bind failure_memory_table fmt_checker u_fmt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (resp.valid),
  .out_ready   (resp.ready),
  .out_blocked (resp.blocked),
  .out_count   (resp.open_fail_count)
);
`default_nettype wire
